[sv/ccfd_pkg.sv]
// ----------------------------------------------------------------------------
// ccfd_pkg
// Shared types and constants for the framed ChaCha20 receive decryptor.
// ----------------------------------------------------------------------------
package ccfd_pkg;

  typedef enum logic [1:0] {
    PH_MAGIC  = 2'd0,
    PH_LEN    = 2'd1,
    PH_NONCE  = 2'd2,
    PH_CIPHER = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CR_IDLE  = 2'd0,
    CR_ROUND = 2'd1,
    CR_FINAL = 2'd2
  } core_state_e;

  localparam logic [2:0] REG_MAGIC = 3'd0;
  localparam logic [2:0] REG_MAXLEN = 3'd1;
  localparam logic [2:0] REG_KEY0 = 3'd2;
  localparam logic [2:0] REG_KEY1 = 3'd3;
  localparam logic [2:0] REG_KEY2 = 3'd4;
  localparam logic [2:0] REG_KEY3 = 3'd5;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // quarter-round index sets: four column then four diagonal
  function automatic logic [15:0] qr_idx(input logic [2:0] q);
    logic [15:0] r;
    case (q)
      3'd0: r = {4'd12, 4'd8, 4'd4, 4'd0};
      3'd1: r = {4'd13, 4'd9, 4'd5, 4'd1};
      3'd2: r = {4'd14, 4'd10, 4'd6, 4'd2};
      3'd3: r = {4'd15, 4'd11, 4'd7, 4'd3};
      3'd4: r = {4'd15, 4'd10, 4'd5, 4'd0};
      3'd5: r = {4'd12, 4'd11, 4'd6, 4'd1};
      3'd6: r = {4'd13, 4'd8, 4'd7, 4'd2};
      default: r = {4'd14, 4'd9, 4'd4, 4'd3};
    endcase
    return r;
  endfunction

endpackage

[sv/ccfd_core.sv]
// ----------------------------------------------------------------------------
// ccfd_core
// ChaCha20 block function: one quarter-round unit reused 80 times,
// then a feed-forward add over 16 words, one word per cycle.
// ----------------------------------------------------------------------------
module ccfd_core
  import ccfd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [255:0] key_i,
  input  logic [95:0]  nonce_i,
  input  logic [31:0]  counter_i,
  output logic         done_o,
  input  logic [3:0]   rd_word_i,
  output logic [31:0]  rd_data_o
);

  core_state_e      state_q, state_d;
  logic [31:0]      x_q [16];
  logic [31:0]      in_q [16];
  logic [6:0]       step_q, step_d;
  logic [31:0]      ks_q [16];
  logic [31:0]      rd_q;

  logic [15:0] idx;
  logic [3:0]  ia, ib, ic, id;
  logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;

  // shared quarter round
  always_comb begin
    idx = qr_idx(step_q[2:0]);
    ia = idx[3:0];
    ib = idx[7:4];
    ic = idx[11:8];
    id = idx[15:12];
    a1 = x_q[ia] + x_q[ib];
    d0 = x_q[id] ^ a1;
    d1 = {d0[15:0], d0[31:16]};
    c1 = x_q[ic] + d1;
    b0 = x_q[ib] ^ c1;
    b1 = {b0[19:0], b0[31:20]};
    a2 = a1 + b1;
    a0 = d1 ^ a2;
    d2 = {a0[23:0], a0[31:24]};
    c2 = c1 + d2;
    c0 = b1 ^ c2;
    b2 = {c0[24:0], c0[31:25]};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_o  = 1'b0;
    unique case (state_q)
      CR_IDLE: begin
        step_d = '0;
        if (start_i) state_d = CR_ROUND;
      end
      CR_ROUND: begin
        step_d = step_q + 7'd1;
        if (step_q == 7'd79) begin
          step_d  = '0;
          state_d = CR_FINAL;
        end
      end
      CR_FINAL: begin
        step_d = step_q + 7'd1;
        if (step_q == 7'd15) begin
          state_d = CR_IDLE;
          done_o  = 1'b1;
        end
      end
      default: state_d = CR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // working state, input copy and keystream words
  always_ff @(posedge clk_i) begin
    if (state_q == CR_IDLE && start_i) begin
      in_q[0] <= SIGMA0; in_q[1] <= SIGMA1; in_q[2] <= SIGMA2; in_q[3] <= SIGMA3;
      x_q[0]  <= SIGMA0; x_q[1]  <= SIGMA1; x_q[2]  <= SIGMA2; x_q[3]  <= SIGMA3;
      for (int i = 0; i < 8; i++) begin
        in_q[4+i] <= key_i[32*i +: 32];
        x_q[4+i]  <= key_i[32*i +: 32];
      end
      in_q[12] <= counter_i;
      x_q[12]  <= counter_i;
      for (int i = 0; i < 3; i++) begin
        in_q[13+i] <= nonce_i[32*i +: 32];
        x_q[13+i]  <= nonce_i[32*i +: 32];
      end
    end else if (state_q == CR_ROUND) begin
      x_q[ia] <= a2;
      x_q[ib] <= b2;
      x_q[ic] <= c2;
      x_q[id] <= d2;
    end else if (state_q == CR_FINAL) begin
      ks_q[step_q[3:0]] <= x_q[step_q[3:0]] + in_q[step_q[3:0]];
    end
    rd_q <= ks_q[rd_word_i];
  end

  assign rd_data_o = rd_q;

endmodule

[sv/chacha20_frame_deframe_decrypt.sv]
// ----------------------------------------------------------------------------
// chacha20_frame_deframe_decrypt
// Receive deframer with ChaCha20 (IETF) decryption of the payload.
// ----------------------------------------------------------------------------
//  channel  direction  content
//  s_axis   in         tdata[7:0] rx_byte
//  m_axis   out        tdata[23:0] {frame_length, plain_byte}, tlast last_byte
//  cfg      in         we/index/data register writes
// A ciphertext byte passes the input, keystream read and output states, plus a
// generate state before the read when a new 64-byte block is due: 80 quarter
// rounds on the single quarter-round unit and 16 feed-forward adds.
// Reset clears all control state; no clearing pass. Output stall holds the
// result register and blocks the next transaction.
module chacha20_frame_deframe_decrypt
  import ccfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // plain_byte, frame_length
  output logic        m_axis_tlast,   // last_byte
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [1:0] {ST_IN, ST_GEN, ST_READ, ST_OUT} seq_e;

  seq_e         seq_q;
  phase_e       phase_q;
  logic [7:0]   magic_q, len_low_q, byte_q;
  logic [15:0]  max_len_q, pay_len_q, idx_q;
  logic [255:0] key_q;
  logic         len_cnt_q;
  logic [95:0]  nonce_q;
  logic [3:0]   ncnt_q;
  logic [31:0]  blk_q;
  logic         ov_q;
  logic [7:0]   ob_q;
  logic         ol_q;
  logic         start;
  logic         done;
  logic [31:0]  ks_word;
  logic [15:0]  len_full;
  logic         last;

  ccfd_core u_core (
    .clk_i, .rst_ni, .start_i(start), .key_i(key_q), .nonce_i(nonce_q),
    .counter_i(blk_q), .done_o(done), .rd_word_i(idx_q[5:2]), .rd_data_o(ks_word)
  );

  assign s_axis_tready = (seq_q == ST_IN) && !ov_q;
  assign start    = (seq_q == ST_GEN);
  assign len_full = {s_axis_tdata, len_low_q};
  assign last     = ({16'd0, idx_q} + 32'd1) >= {16'd0, pay_len_q};
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {pay_len_q, ob_q};
  assign m_axis_tlast  = ol_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      max_len_q <= 16'd280;
      key_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAGIC:  magic_q <= cfg_data_i[7:0];
        REG_MAXLEN: max_len_q <= cfg_data_i[15:0];
        REG_KEY0:   key_q[63:0] <= cfg_data_i;
        REG_KEY1:   key_q[127:64] <= cfg_data_i;
        REG_KEY2:   key_q[191:128] <= cfg_data_i;
        REG_KEY3:   key_q[255:192] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // nonce bytes, received byte and length low byte
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready && phase_q == PH_NONCE)
      nonce_q[8*ncnt_q +: 8] <= s_axis_tdata;
    if (s_axis_tvalid && s_axis_tready) byte_q <= s_axis_tdata;
    if (s_axis_tvalid && s_axis_tready && phase_q == PH_LEN && !len_cnt_q)
      len_low_q <= s_axis_tdata;
  end

  // framing and sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= ST_IN;
      phase_q   <= PH_MAGIC;
      len_cnt_q <= 1'b0;
      pay_len_q <= '0;
      ncnt_q    <= '0;
      idx_q     <= '0;
      blk_q     <= '0;
      ov_q      <= 1'b0;
      ob_q      <= '0;
      ol_q      <= 1'b0;
    end else begin
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      unique case (seq_q)
        ST_IN: begin
          if (s_axis_tvalid && s_axis_tready) begin
            unique case (phase_q)
              PH_MAGIC: if (s_axis_tdata == magic_q) begin
                len_cnt_q <= 1'b0;
                phase_q   <= PH_LEN;
              end
              PH_LEN: begin
                if (!len_cnt_q) len_cnt_q <= 1'b1;
                else begin
                  len_cnt_q <= 1'b0;
                  pay_len_q <= len_full;
                  if (len_full == 16'd0 || len_full > max_len_q) phase_q <= PH_MAGIC;
                  else begin
                    ncnt_q  <= '0;
                    phase_q <= PH_NONCE;
                  end
                end
              end
              PH_NONCE: begin
                if (ncnt_q == 4'd11) begin
                  ncnt_q  <= '0;
                  idx_q   <= '0;
                  blk_q   <= '0;
                  phase_q <= PH_CIPHER;
                end else ncnt_q <= ncnt_q + 4'd1;
              end
              PH_CIPHER: seq_q <= (idx_q[5:0] == 6'd0) ? ST_GEN : ST_READ;
              default: ;
            endcase
          end
        end
        ST_GEN: if (done) begin
          blk_q <= blk_q + 32'd1;
          seq_q <= ST_READ;
        end
        ST_READ: seq_q <= ST_OUT;
        ST_OUT: begin
          ob_q <= byte_q ^ ks_word[8*idx_q[1:0] +: 8];
          ol_q <= last;
          ov_q <= 1'b1;
          if (last) begin
            idx_q   <= '0;
            phase_q <= PH_MAGIC;
          end else idx_q <= idx_q + 16'd1;
          seq_q <= ST_IN;
        end
        default: seq_q <= ST_IN;
      endcase
    end
  end

endmodule
